// File: rtl/cpds_pkg.sv
// shared types, codes and segment tables for the clock program display scheduler
`timescale 1ns / 1ps

package cpds_pkg;

	// item function codes
	typedef enum logic [1:0] {
		FUNC_TICK      = 2'd0,
		FUNC_LOAD_TIME = 2'd1,
		FUNC_LOAD_TEMP = 2'd2
	} func_t;

	// display programs
	typedef enum logic [1:0] {
		PROG_TIME   = 2'd0,
		PROG_TEMP   = 2'd1,
		PROG_BOTH   = 2'd2,
		PROG_SILENT = 2'd3
	} prog_t;

	// switch pin positions (active low on the pins)
	localparam int SW_TEMP   = 0;
	localparam int SW_BOTH   = 1;
	localparam int SW_TIME   = 2;
	localparam int SW_SILENT = 3;

	// glyphs
	localparam logic [6:0] SEG_MINUS  = 7'b1000000;
	localparam logic [6:0] SEG_DEGREE = 7'b1100011;
	localparam logic [6:0] SEG_CEL    = 7'b0001111;
	localparam logic [6:0] SEG_MARK   = 7'b0001001;
	localparam logic [7:0] SYNC_DOT   = 8'h77;

	// clock reset values
	localparam logic [5:0] SEC_RESET  = 6'd57;
	localparam logic [5:0] MIN_RESET  = 6'd41;
	localparam logic [4:0] HOUR_RESET = 5'd23;
	localparam logic signed [7:0] TEMP_RESET = 8'sd42;

	// decimal digit to segment pattern
	function automatic logic [6:0] seg_digit(input logic [3:0] d);
		logic [6:0] s;
		case (d)
			4'd0: s = 7'b0111111;
			4'd1: s = 7'b0110000;
			4'd2: s = 7'b1101101;
			4'd3: s = 7'b1111001;
			4'd4: s = 7'b1110010;
			4'd5: s = 7'b1011011;
			4'd6: s = 7'b1011111;
			4'd7: s = 7'b0110001;
			4'd8: s = 7'b1111111;
			4'd9: s = 7'b1111011;
			default: s = 7'b0000000;
		endcase
		return s;
	endfunction

	// tens digit of a value below 100, by parallel compares
	function automatic logic [3:0] tens_of(input logic [6:0] v);
		logic [3:0] t;
		if (v >= 7'd90)      t = 4'd9;
		else if (v >= 7'd80) t = 4'd8;
		else if (v >= 7'd70) t = 4'd7;
		else if (v >= 7'd60) t = 4'd6;
		else if (v >= 7'd50) t = 4'd5;
		else if (v >= 7'd40) t = 4'd4;
		else if (v >= 7'd30) t = 4'd3;
		else if (v >= 7'd20) t = 4'd2;
		else if (v >= 7'd10) t = 4'd1;
		else                 t = 4'd0;
		return t;
	endfunction

	// ones digit given the tens digit
	function automatic logic [3:0] ones_of(input logic [6:0] v, input logic [3:0] t);
		logic [6:0] r;
		r = v - 7'({3'd0, t} * 7'd10);
		return r[3:0];
	endfunction

endpackage

// File: rtl/clock_program_display_scheduler_unit.sv
// top level: clock, program select and display word scheduler
`timescale 1ns / 1ps

// path: an accepted transaction is registered in the input register, and its result is
//   loaded into the output register when the compute stage advances
// throughput: one transaction per cycle while the output is not stalled, set by
//   the single compute stage between the input register and the output register
// reset: arst_n clears valids and sets the clock to 23:41:57, temperature 42,
//   sync status 0, time program and the time request armed
module clock_program_display_scheduler_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  func,
	input  logic [3:0]  switches,
	input  logic [4:0]  new_hours,
	input  logic [5:0]  new_minutes,
	input  logic [5:0]  new_seconds,
	input  logic [7:0]  new_sync_status,
	input  logic signed [7:0] new_temperature,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] display_word,
	output logic        word_valid,
	output logic        request_temp,
	output logic        request_time,
	output logic [1:0]  program_res,
	output logic [4:0]  hours,
	output logic [5:0]  minutes,
	output logic [5:0]  seconds
);
	import cpds_pkg::*;

	// input register
	logic        valid_s1;
	logic [1:0]  func_s1;
	logic [3:0]  switches_s1;
	logic [4:0]  new_hours_s1;
	logic [5:0]  new_minutes_s1;
	logic [5:0]  new_seconds_s1;
	logic [7:0]  new_sync_s1;
	logic signed [7:0] new_temp_s1;

	// block state
	logic [5:0]  sec_q;
	logic [5:0]  min_q;
	logic [4:0]  hour_q;
	logic [7:0]  sync_q;
	logic signed [7:0] temp_q;
	prog_t       prog_q;
	logic        armed_q;

	// next state and result
	logic [5:0]  sec_n;
	logic [5:0]  min_n;
	logic [4:0]  hour_n;
	logic [7:0]  sync_n;
	logic signed [7:0] temp_n;
	prog_t       prog_n;
	logic        armed_n;
	logic [31:0] word_n;
	logic        wvalid_n;
	logic        rtemp_n;
	logic        rtime_n;

	logic        advance;
	logic [3:0]  low;
	logic        sec_wrap;
	logic        min_wrap;
	logic [5:0]  sec_tick;
	logic [5:0]  min_tick;
	logic [4:0]  hour_tick;
	logic [31:0] time_word;
	logic [31:0] temp_word;

	// handshake: the output register frees the compute stage
	assign advance  = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			func_s1        <= func;
			switches_s1    <= switches;
			new_hours_s1   <= new_hours;
			new_minutes_s1 <= new_minutes;
			new_seconds_s1 <= new_seconds;
			new_sync_s1    <= new_sync_status;
			new_temp_s1    <= new_temperature;
		end
	end

	// clock after one tick, with carries
	assign sec_tick  = sec_wrap ? 6'd0 : sec_q + 6'd1;
	assign min_tick  = !sec_wrap ? min_q : (min_wrap ? 6'd0 : min_q + 6'd1);
	assign hour_tick = !(sec_wrap && min_wrap) ? hour_q :
		((hour_q >= 5'd23) ? 5'd0 : hour_q + 5'd1);

	// time word from the ticked clock
	always_comb begin
		logic [6:0] hv;
		logic [6:0] mv;
		logic [3:0] ht;
		logic [3:0] mt;
		hv = {2'd0, hour_tick};
		mv = {1'd0, min_tick};
		ht = tens_of(hv);
		mt = tens_of(mv);
		time_word = {1'b0, seg_digit(ht), 1'b0, seg_digit(ones_of(hv, ht)),
			(sync_q == SYNC_DOT), seg_digit(mt), 1'b0, seg_digit(ones_of(mv, mt))};
	end

	// temperature word, clamped to the displayable range
	always_comb begin
		logic signed [7:0] t;
		logic [6:0] tv;
		logic [3:0] tt;
		logic [7:0] mag;
		t = temp_q;
		if (t < -8'sd9) t = -8'sd9;
		if (t > 8'sd99) t = 8'sd99;
		tv  = t[6:0];
		tt  = tens_of(tv);
		mag = -t;
		if (t < 8'sd0) begin
			temp_word = {1'b0, SEG_MINUS, 1'b0, seg_digit(mag[3:0]),
				1'b0, SEG_DEGREE, 1'b0, SEG_CEL};
		end else if (t < 8'sd10) begin
			temp_word = {1'b0, seg_digit(tv[3:0]), 1'b0, SEG_DEGREE,
				1'b0, SEG_CEL, 1'b0, SEG_MARK};
		end else begin
			temp_word = {1'b0, seg_digit(tt), 1'b0, seg_digit(ones_of(tv, tt)),
				1'b0, SEG_DEGREE, 1'b0, SEG_CEL};
		end
	end

	assign low      = ~switches_s1;
	assign sec_wrap = (sec_q >= 6'd59);
	assign min_wrap = (min_q >= 6'd59);

	// per-transaction update
	always_comb begin
		sec_n    = sec_q;
		min_n    = min_q;
		hour_n   = hour_q;
		sync_n   = sync_q;
		temp_n   = temp_q;
		prog_n   = prog_q;
		armed_n  = armed_q;
		word_n   = 32'd0;
		wvalid_n = 1'b0;
		rtemp_n  = 1'b0;
		rtime_n  = 1'b0;
		case (func_s1)
			FUNC_TICK: begin
				// clock advance with carries
				sec_n  = sec_tick;
				min_n  = min_tick;
				hour_n = hour_tick;
				// program pick, first matching pin wins
				if (prog_q != PROG_TEMP && low[SW_TEMP])            prog_n = PROG_TEMP;
				else if (prog_q != PROG_BOTH && low[SW_BOTH])       prog_n = PROG_BOTH;
				else if (prog_q != PROG_TIME && low[SW_TIME])       prog_n = PROG_TIME;
				else if (prog_q != PROG_SILENT && low[SW_SILENT])   prog_n = PROG_SILENT;
				// read requests
				rtemp_n = (sec_n == 6'd15);
				if (sec_n == 6'd45 && armed_q) begin
					armed_n = 1'b0;
					rtime_n = 1'b1;
				end
				if (sec_n == 6'd46) armed_n = 1'b1;
				// display scheduling
				if (sec_n == 6'd30 && (prog_n == PROG_TEMP || prog_n == PROG_BOTH)) begin
					word_n   = temp_word;
					wvalid_n = 1'b1;
				end
				if (sec_n == 6'd0 && (prog_n == PROG_TIME || prog_n == PROG_BOTH ||
					(prog_n == PROG_SILENT && (min_n == 6'd0 || min_n == 6'd15 ||
					min_n == 6'd30 || min_n == 6'd45)))) begin
					word_n   = time_word;
					wvalid_n = 1'b1;
				end
			end
			FUNC_LOAD_TIME: begin
				hour_n = new_hours_s1;
				min_n  = new_minutes_s1;
				sec_n  = new_seconds_s1;
				sync_n = new_sync_s1;
			end
			FUNC_LOAD_TEMP: begin
				if (new_temp_s1 > 8'sd99)       temp_n = 8'sd99;
				else if (new_temp_s1 < -8'sd9)  temp_n = -8'sd9;
				else                            temp_n = new_temp_s1;
			end
			default: begin
			end
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sec_q   <= SEC_RESET;
			min_q   <= MIN_RESET;
			hour_q  <= HOUR_RESET;
			sync_q  <= 8'd0;
			temp_q  <= TEMP_RESET;
			prog_q  <= PROG_TIME;
			armed_q <= 1'b1;
		end else if (advance) begin
			sec_q   <= sec_n;
			min_q   <= min_n;
			hour_q  <= hour_n;
			sync_q  <= sync_n;
			temp_q  <= temp_n;
			prog_q  <= prog_n;
			armed_q <= armed_n;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			display_word <= word_n;
			word_valid   <= wvalid_n;
			request_temp <= rtemp_n;
			request_time <= rtime_n;
			program_res  <= prog_n;
			hours        <= hour_n;
			minutes      <= min_n;
			seconds      <= sec_n;
		end
	end

	// at most one event per result
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $onehot0({word_valid, request_temp, request_time}))
		else $error("more than one event flagged in one result");

	// time requests only at second 45
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && request_time |-> seconds == 6'd45)
		else $error("time request away from second 45");

	// display words only at second 0 or 30
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && word_valid |-> (seconds == 6'd0 || seconds == 6'd30))
		else $error("display word at an unscheduled second");

	// a stalled compute stage keeps its transaction
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(func_s1))
		else $error("stalled transaction lost from input register");

endmodule
